// File: src/event_ring_interrupt_moderator_macros.svh
// assertion helpers for the event ring interrupt moderator
`ifndef EVENT_RING_INTERRUPT_MODERATOR_MACROS_SVH
`define EVENT_RING_INTERRUPT_MODERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define ERIM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("erim: same-cycle check failed");

// next-cycle implication, checked outside reset
`define ERIM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("erim: next-cycle check failed");

`endif

// File: src/erim_pkg.sv
`default_nettype none
package erim_pkg;

	// ring geometry (depth is a power of two)
	localparam int RING_DEPTH = 256;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int ENTRY_W    = 8;

	// field widths
	localparam int KIND_W    = 2;
	localparam int TYPE_W    = 4;
	localparam int PORT_W    = 4;
	localparam int COUNT_W   = 8;
	localparam int INDEX_W   = 8;
	localparam int POS_W     = 8;
	localparam int TIME_W    = 32;
	localparam int TMO_W     = 20;
	localparam int MASK_W    = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 20;

	// moderation constants
	localparam logic [TIME_W-1:0] SHORT_DELAY = TIME_W'(1000);
	// timeout_us*192/10 = timeout_us*19 + timeout_us/5
	localparam logic [TIME_W-1:0] TICKS_INT   = TIME_W'(19);
	localparam logic [31:0]       RECIP5      = 32'hCCCC_CCCD;
	localparam int                RECIP5_SH   = 34;
	localparam int                DIVPROD_W   = TMO_W + 32;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_POST    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ    = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_MASK  = 4'd1;
	localparam logic [MASK_W-1:0]    MASK_RESET      = 16'hFFFF;

	// ring access request from the control logic
	typedef struct packed {
		logic               we;
		logic [PTR_W-1:0]   waddr;
		logic [ENTRY_W-1:0] wdata;
		logic               re;
		logic [PTR_W-1:0]   raddr;
	} ring_req_t;

	// registered result fields, entry data comes from the ring read port
	typedef struct packed {
		logic             irq_fire;
		logic             event_dropped;
		logic             event_masked;
		logic [PTR_W-1:0] fill;
		logic [PTR_W-1:0] rd_pos;
		logic [PTR_W-1:0] wr_pos;
		logic             rd_sel;
	} result_t;

endpackage
`default_nettype wire

// File: src/erim_if.sv
`default_nettype none
// input item channel
interface erim_item_if;
	import erim_pkg::*;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [TYPE_W-1:0]  evt_code;
	logic [PORT_W-1:0]  port_number;
	logic [COUNT_W-1:0] release_count;
	logic [INDEX_W-1:0] entry_index;
	modport source(output valid, kind, evt_code, port_number, release_count, entry_index,
		input ready);
	modport sink(input valid, kind, evt_code, port_number, release_count, entry_index,
		output ready);
endinterface

// result item channel
interface erim_result_if;
	import erim_pkg::*;
	logic               valid;
	logic               ready;
	logic               irq_fire;
	logic               event_dropped;
	logic               event_masked;
	logic [POS_W-1:0]   fill_depth;
	logic [POS_W-1:0]   read_position;
	logic [POS_W-1:0]   write_position;
	logic [ENTRY_W-1:0] entry_data;
	modport source(output valid, irq_fire, event_dropped, event_masked, fill_depth,
		read_position, write_position, entry_data, input ready);
	modport sink(input valid, irq_fire, event_dropped, event_masked, fill_depth,
		read_position, write_position, entry_data, output ready);
endinterface

// register write channel
interface erim_cfg_if;
	import erim_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] idx;
	logic [CFG_DAT_W-1:0] data;
	modport source(output valid, idx, data, input ready);
	modport sink(input valid, idx, data, output ready);
endinterface
`default_nettype wire

// File: src/event_ring_interrupt_moderator.sv
// Event ring with interrupt moderation.
// item channel: post (kind 0) stores {evt_code, port_number} in the ring,
// release (kind 1) advances the read pointer, tick (kind 2) advances time and
// the moderation timer, read (kind 3) returns one ring slot.
// result channel: one result item per input item, with flags, both pointers,
// fill depth and, for reads, the slot content.
// cfg channel: index 0 timeout_us, index 1 event_enable_mask; always ready.
// The result is registered and valid in the cycle after acceptance; an item
// can be taken every cycle unless the result stalls or a cfg write settles.
// The ring is a 256 x 8 memory with a registered read port; a read issued at
// acceptance returns its data together with the result. The tick threshold is
// registered from timeout_us, so item ready is low the cycle after each write.
// Reset clears pointers, timer, time counters and the slot written flags, so
// every slot reads as zero until posted; there is no clearing pass.
// When the result receiver stalls, the result stays registered and the item
// channel stops accepting until the result is taken.
`default_nettype none
`include "event_ring_interrupt_moderator_macros.svh"
module event_ring_interrupt_moderator (
	input  logic          clk,
	input  logic          arst_n,
	erim_item_if.sink     item,
	erim_result_if.source result,
	erim_cfg_if.sink      cfg
);
	import erim_pkg::*;

	// registers
	logic [TMO_W-1:0]  timeout_q;
	logic [MASK_W-1:0] mask_q;
	logic [TIME_W-1:0] limit_q;
	logic              settle_q;
	logic [PTR_W-1:0]  wp_q, rp_q;
	logic              timer_on_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] elapsed_q;
	result_t           res_q;
	logic              res_valid_q;

	// next state
	logic [PTR_W-1:0]  wp_d, rp_d;
	logic              timer_on_d;
	logic [TIME_W-1:0] rem_d, elapsed_d;
	result_t           res_d;

	logic                 acc, cfg_acc;
	logic                 type_en, full;
	logic [PTR_W-1:0]     wp_inc;
	logic [TIME_W:0]      gap;
	logic [TIME_W-1:0]    arm_val, rem_dec;
	logic                 tick_fire;
	logic [15:0]          rel_sum;
	logic [DIVPROD_W-1:0] div_prod;
	ring_req_t            ring_req;
	logic [ENTRY_W-1:0]   ring_data;

	assign cfg_acc    = cfg.valid && cfg.ready;
	assign cfg.ready  = 1'b1;
	assign item.ready = (!res_valid_q || result.ready) && !settle_q;
	assign acc        = item.valid && item.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= '0;
			mask_q    <= MASK_RESET;
			settle_q  <= 1'b0;
			limit_q   <= '0;
		end else begin
			settle_q <= cfg_acc;
			limit_q  <= TIME_W'(timeout_q) * TICKS_INT + TIME_W'(div_prod >> RECIP5_SH);
			if (cfg_acc) begin
				unique case (cfg.idx)
					REG_TIMEOUT_US: timeout_q <= cfg.data[TMO_W-1:0];
					REG_EVENT_MASK: mask_q    <= cfg.data[MASK_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// timeout_us / 5 by reciprocal multiply
	assign div_prod = DIVPROD_W'(timeout_q) * DIVPROD_W'(RECIP5);

	// post, timer and pointer arithmetic
	assign type_en   = mask_q[item.evt_code];
	assign wp_inc    = wp_q + 1'b1;
	assign full      = (wp_inc == rp_q);
	assign gap       = {1'b0, limit_q} - {1'b0, elapsed_q};
	assign arm_val   = gap[TIME_W] ? SHORT_DELAY : gap[TIME_W-1:0];
	assign rem_dec   = (rem_q != '0) ? rem_q - 1'b1 : '0;
	assign tick_fire = timer_on_q && (rem_dec == '0);
	assign rel_sum   = 16'(rp_q) + 16'(item.release_count);

	always_comb begin
		wp_d       = wp_q;
		rp_d       = rp_q;
		timer_on_d = timer_on_q;
		rem_d      = rem_q;
		elapsed_d  = elapsed_q;
		res_d      = '0;
		case (item.kind)
			KIND_POST: begin
				if (!type_en) begin
					res_d.event_masked = 1'b1;
				end else if (full) begin
					res_d.event_dropped = 1'b1;
				end else begin
					wp_d = wp_inc;
					if (!timer_on_q) begin
						timer_on_d = 1'b1;
						rem_d      = arm_val;
					end
				end
			end
			KIND_RELEASE: begin
				rp_d = rel_sum[PTR_W-1:0];
			end
			KIND_TICK: begin
				elapsed_d = tick_fire ? '0 : elapsed_q + 1'b1;
				if (timer_on_q) begin
					rem_d = rem_dec;
				end
				if (tick_fire) begin
					res_d.irq_fire = 1'b1;
					timer_on_d     = 1'b0;
				end
			end
			default: begin
				res_d.rd_sel = 1'b1;
			end
		endcase
		res_d.fill   = wp_d - rp_d;
		res_d.rd_pos = rp_d;
		res_d.wr_pos = wp_d;
	end

	// ring access
	always_comb begin
		ring_req.we    = acc && (item.kind == KIND_POST) && type_en && !full;
		ring_req.waddr = wp_q;
		ring_req.wdata = {item.evt_code, item.port_number};
		ring_req.re    = acc && (item.kind == KIND_READ);
		ring_req.raddr = item.entry_index[PTR_W-1:0];
	end

	erim_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ring_req),
		.rd_data (ring_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			timer_on_q  <= 1'b0;
			rem_q       <= '0;
			elapsed_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				wp_q       <= wp_d;
				rp_q       <= rp_d;
				timer_on_q <= timer_on_d;
				rem_q      <= rem_d;
				elapsed_q  <= elapsed_d;
			end
			if (acc) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (acc) begin
			res_q <= res_d;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.irq_fire       = res_q.irq_fire;
	assign result.event_dropped  = res_q.event_dropped;
	assign result.event_masked   = res_q.event_masked;
	assign result.fill_depth     = POS_W'(res_q.fill);
	assign result.read_position  = POS_W'(res_q.rd_pos);
	assign result.write_position = POS_W'(res_q.wr_pos);
	assign result.entry_data     = res_q.rd_sel ? ring_data : '0;

	// checks
	`ERIM_ASSERT_NEXT(a_result_follows, acc, res_valid_q)
	`ERIM_ASSERT_NEXT(a_settle_blocks, cfg_acc, !item.ready)
	`ERIM_ASSERT_NEXT(a_fire_stops_timer, acc && (item.kind == KIND_TICK) && tick_fire, !timer_on_q && (elapsed_q == '0))
	`ERIM_ASSERT_NOW(a_no_write_on_read, ring_req.we, !ring_req.re)

endmodule
`default_nettype wire

// File: src/erim_ring.sv
`default_nettype none
module erim_ring (
	input  logic                          clk,
	input  logic                          arst_n,
	input  erim_pkg::ring_req_t           req,
	output logic [erim_pkg::ENTRY_W-1:0]  rd_data
);
	import erim_pkg::*;

	logic [ENTRY_W-1:0]    mem [RING_DEPTH];
	logic [RING_DEPTH-1:0] vld_q;
	logic [ENTRY_W-1:0]    rdata_q;
	logic                  rvld_q;

	// ring storage, one write and one read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	// written flags so untouched slots read as zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rvld_q <= vld_q[req.raddr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule
`default_nettype wire
